/* design/bmvs_pkg.sv */
// ----------------------------------------------------------------------------
// bmvs_pkg: shared constants and types
// Field widths, register indexes, reset values and the clamped configuration
// bundle used by the block mean/variance engine.
// ----------------------------------------------------------------------------
package bmvs_pkg;

	localparam int MAX_SIDE_DEF = 128;
	localparam int MAX_DEPTH    = 10;

	localparam int PIX_W     = 10;
	localparam int CFG_W     = 8;
	localparam int DEPTH_W   = 4;
	localparam int K_W       = 4;
	localparam int MEAN_W    = 16;
	localparam int VAR_W     = 23;
	localparam int FRAC_W    = 8;
	localparam int CFG_IDX_W = 3;

	localparam int QUEUE_DEPTH = 2;

	// register indexes of the write port
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH  = 3'd3;

	localparam logic [CFG_W-1:0]   WIDTH_RST  = 8'd16;
	localparam logic [CFG_W-1:0]   HEIGHT_RST = 8'd16;
	localparam logic [CFG_W-1:0]   STEP_RST   = 8'd1;
	localparam logic [DEPTH_W-1:0] DEPTH_RST  = 4'd8;

	localparam logic [DEPTH_W-1:0] BASE_DEPTH = 4'd8;
	localparam logic [DEPTH_W-1:0] TOP_DEPTH  = DEPTH_W'(MAX_DEPTH);
	localparam logic [K_W-1:0]     MAX_SHIFT  = K_W'(MAX_DEPTH - 8);

	localparam logic [MEAN_W-1:0] MEAN_MAX = 16'hFFFF;
	localparam logic [VAR_W-1:0]  VAR_MAX  = 23'd4194304;

	// configuration after clamping, as the front end consumes it
	typedef struct packed {
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
		logic [CFG_W-1:0] step;
		logic [K_W-1:0]   shift;
	} blk_cfg_t;

	// bit width of one queued job for a given maximum block side
	function automatic int job_width(int max_side);
		int side_w;
		int sum_w;
		int sq_w;
		side_w = $clog2(max_side + 1);
		sum_w  = PIX_W + 2 * $clog2(max_side);
		sq_w   = 2 * PIX_W + 2 * $clog2(max_side);
		return 2 * side_w + K_W + sum_w + sq_w;
	endfunction

endpackage

/* design/block_mean_variance_vertical_subsample.sv */
// ----------------------------------------------------------------------------
// block_mean_variance_vertical_subsample: block mean and variance
// Pixels of a block enter on the in_valid/in_ready channel in raster order,
// one per cycle. Rows whose index is a multiple of row_step are summed.
// After the last pixel of the block, one transaction on out_valid/out_ready
// carries mean_fx and variance_fx at 8-bit scale with 8 fractional bits.
// Registers are written through cfg_we/cfg_index/cfg_data (0 width, 1 height,
// 2 row step, 3 pixel depth); a write to these restarts the current block.
// The front end takes one pixel per cycle. A finished block is handed to the
// back end through a two-entry job queue; the back end works on one block at a
// time, paced by the shared one-bit-per-cycle divider that produces the mean
// and then the variance. in_ready drops only on the last pixel of a block
// while the queue is full. Reset clears counters, sums, queue and output
// valid, and loads the default configuration (16x16, every row, 8-bit
// pixels). A stalled output holds its result; the back end waits, then the
// queue fills, then input.
// ----------------------------------------------------------------------------
module block_mean_variance_vertical_subsample import bmvs_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MEAN_W-1:0]    mean_fx,
	output logic [VAR_W-1:0]     variance_fx
);

	localparam int LOG_SIDE = $clog2(MAX_SIDE);
	localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
	localparam int SUM_W    = PIX_W + 2 * LOG_SIDE;
	localparam int SQ_W     = 2 * PIX_W + 2 * LOG_SIDE;
	localparam int JOB_W    = 2 * SIDE_W + K_W + SUM_W + SQ_W;

	// raw configuration registers
	logic [CFG_W-1:0]   width_q;
	logic [CFG_W-1:0]   height_q;
	logic [CFG_W-1:0]   step_q;
	logic [DEPTH_W-1:0] depth_q;

	logic               cfg_hit;
	blk_cfg_t           cfg;

	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_valid;
	logic [JOB_W-1:0]   q_din;
	logic [JOB_W-1:0]   q_dout;

	// decode the write; an index past the register list is dropped
	always_comb begin
		case (cfg_index)
			REG_BLOCK_WIDTH:  cfg_hit = 1'b1;
			REG_BLOCK_HEIGHT: cfg_hit = 1'b1;
			REG_ROW_STEP:     cfg_hit = 1'b1;
			REG_PIXEL_DEPTH:  cfg_hit = 1'b1;
			default:          cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			step_q   <= STEP_RST;
			depth_q  <= DEPTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_WIDTH:  width_q  <= cfg_data;
				REG_BLOCK_HEIGHT: height_q <= cfg_data;
				REG_ROW_STEP:     step_q   <= cfg_data;
				REG_PIXEL_DEPTH:  depth_q  <= cfg_data[DEPTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp sides to 1..MAX_SIDE, step zero acts as one, depth to 8..MAX_DEPTH
	always_comb begin
		if (width_q == '0) begin
			cfg.width = CFG_W'(1);
		end else if (width_q > CFG_W'(MAX_SIDE)) begin
			cfg.width = CFG_W'(MAX_SIDE);
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = CFG_W'(1);
		end else if (height_q > CFG_W'(MAX_SIDE)) begin
			cfg.height = CFG_W'(MAX_SIDE);
		end else begin
			cfg.height = height_q;
		end
		cfg.step = (step_q == '0) ? CFG_W'(1) : step_q;
		if (depth_q < BASE_DEPTH) begin
			cfg.shift = '0;
		end else if (depth_q > TOP_DEPTH) begin
			cfg.shift = MAX_SHIFT;
		end else begin
			cfg.shift = K_W'(depth_q - BASE_DEPTH);
		end
	end

	bmvs_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.clear   (cfg_we && cfg_hit),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel   (pixel),
		.q_full  (q_full),
		.push    (q_push),
		.job     (q_din)
	);

	bmvs_queue #(
		.W    (JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.dout  (q_dout)
	);

	bmvs_back #(
		.MAX_SIDE(MAX_SIDE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (q_valid),
		.job        (q_dout),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mean_fx    (mean_fx),
		.variance_fx(variance_fx)
	);

	// a delivered variance never exceeds its saturation level
	a_var_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (variance_fx <= VAR_MAX))
		else $error("variance above saturation level");

	// input stalls only because the job queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_full)
		else $error("input stalled with room in the job queue");

	// the front end never pushes a job into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into full queue");

endmodule

/* design/bmvs_queue.sv */
// ----------------------------------------------------------------------------
// bmvs_queue: short job queue
// Register-based FIFO between the accumulating front end and the divide
// back end. Push is only issued when not full.
// ----------------------------------------------------------------------------
module bmvs_queue import bmvs_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] dout
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

/* design/bmvs_front.sv */
// ----------------------------------------------------------------------------
// bmvs_front: pixel accumulator
// Walks the block in raster order, sums used rows and their squares, counts
// complete row groups and pushes one job at the last pixel of the block.
// ----------------------------------------------------------------------------
module bmvs_front import bmvs_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  blk_cfg_t                        cfg,
	input  logic                            clear,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [PIX_W-1:0]                pixel,
	input  logic                            q_full,
	output logic                            push,
	output logic [job_width(MAX_SIDE)-1:0]  job
);

	localparam int LOG_SIDE = $clog2(MAX_SIDE);
	localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
	localparam int SUM_W    = PIX_W + 2 * LOG_SIDE;
	localparam int SQ_W     = 2 * PIX_W + 2 * LOG_SIDE;

	logic [LOG_SIDE-1:0] col_q;
	logic [LOG_SIDE-1:0] row_q;
	logic [CFG_W-1:0]    phase_q;
	logic [SIDE_W-1:0]   groups_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]     sq_q;

	logic                use_row;
	logic [2*PIX_W-1:0]  px_sq;
	logic [SUM_W-1:0]    sum_nxt;
	logic [SQ_W-1:0]     sq_nxt;
	logic                col_last;
	logic                row_last;
	logic                phase_wrap;
	logic [SIDE_W-1:0]   groups_nxt;
	logic                blk_last;
	logic                accept;

	always_comb begin
		use_row    = (phase_q == '0);
		px_sq      = (2*PIX_W)'(pixel) * (2*PIX_W)'(pixel);
		sum_nxt    = use_row ? sum_q + SUM_W'(pixel) : sum_q;
		sq_nxt     = use_row ? sq_q + SQ_W'(px_sq) : sq_q;
		col_last   = ((CFG_W'(col_q) + CFG_W'(1)) == cfg.width);
		row_last   = ((CFG_W'(row_q) + CFG_W'(1)) == cfg.height);
		phase_wrap = ((phase_q + CFG_W'(1)) == cfg.step);
		groups_nxt = groups_q + SIDE_W'(phase_wrap);
		blk_last   = col_last && row_last;
		in_ready   = !(blk_last && q_full);
		accept     = in_valid && in_ready;
		push       = accept && blk_last;
		job        = {groups_nxt, SIDE_W'(cfg.width), cfg.shift, sum_nxt, sq_nxt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			phase_q  <= '0;
			groups_q <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
		end else if (clear) begin
			col_q    <= '0;
			row_q    <= '0;
			phase_q  <= '0;
			groups_q <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
		end else if (accept) begin
			sum_q <= blk_last ? '0 : sum_nxt;
			sq_q  <= blk_last ? '0 : sq_nxt;
			if (!col_last) begin
				col_q <= col_q + LOG_SIDE'(1);
			end else begin
				col_q <= '0;
				if (row_last) begin
					row_q    <= '0;
					phase_q  <= '0;
					groups_q <= '0;
				end else begin
					row_q    <= row_q + LOG_SIDE'(1);
					phase_q  <= phase_wrap ? '0 : phase_q + CFG_W'(1);
					groups_q <= groups_nxt;
				end
			end
		end
	end

endmodule

/* design/bmvs_div.sv */
// ----------------------------------------------------------------------------
// bmvs_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. Pulses done when the
// quotient is ready.
// ----------------------------------------------------------------------------
module bmvs_div import bmvs_pkg::*; #(
	parameter int DVD_W = 57,
	parameter int DVS_W = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule

/* design/bmvs_back.sv */
// ----------------------------------------------------------------------------
// bmvs_back: statistics back end
// Pops one job, forms count, products and the variance numerator, runs the
// mean and then the variance through the shared divider, and holds the
// result in the output register until taken.
// ----------------------------------------------------------------------------
module bmvs_back import bmvs_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	input  logic [job_width(MAX_SIDE)-1:0]  job,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [MEAN_W-1:0]               mean_fx,
	output logic [VAR_W-1:0]                variance_fx
);

	localparam int LOG_SIDE = $clog2(MAX_SIDE);
	localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
	localparam int CNT_W    = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int SUM_W    = PIX_W + 2 * LOG_SIDE;
	localparam int SQ_W     = 2 * PIX_W + 2 * LOG_SIDE;
	localparam int LO_W     = SQ_W / 2;
	localparam int HI_W     = SQ_W - LO_W;
	localparam int NUM_W    = CNT_W + SQ_W;
	localparam int DVD_W    = NUM_W + FRAC_W;
	localparam int DVS_W    = 2 * CNT_W;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_CNT  = 8'b00000010,
		ST_PROD = 8'b00000100,
		ST_SUMA = 8'b00001000,
		ST_DIFF = 8'b00010000,
		ST_DIVM = 8'b00100000,
		ST_DIVV = 8'b01000000,
		ST_OUT  = 8'b10000000
	} back_state_t;

	back_state_t state_q;

	logic [SIDE_W-1:0]      groups_q;
	logic [SIDE_W-1:0]      width_q;
	logic [K_W-1:0]         shift_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]        sq_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   zero_q;
	logic [2*SUM_W-1:0]     b_q;
	logic [CNT_W+LO_W-1:0]  plo_q;
	logic [CNT_W+HI_W-1:0]  phi_q;
	logic [DVS_W-1:0]       csq_q;
	logic [NUM_W-1:0]       a_q;
	logic [DVD_W-1:0]       vnum_q;
	logic [MEAN_W-1:0]      mean_q;
	logic                   out_valid_q;
	logic [MEAN_W-1:0]      mean_out_q;
	logic [VAR_W-1:0]       var_out_q;

	logic [2*SIDE_W-1:0]    cnt_full;
	logic [2*SUM_W-1:0]     b_full;
	logic [CNT_W+LO_W-1:0]  plo_full;
	logic [CNT_W+HI_W-1:0]  phi_full;
	logic [DVS_W-1:0]       csq_full;
	logic [NUM_W:0]         diff;
	logic [DVD_W-1:0]       mean_dvd;
	logic                   div_start;
	logic [DVD_W-1:0]       div_dvd;
	logic [DVS_W-1:0]       div_dvs;
	logic                   div_done;
	logic [DVD_W-1:0]       div_quo;
	logic [MEAN_W-1:0]      mean_sat;
	logic [VAR_W-1:0]       var_sat;
	logic                   out_free;

	always_comb begin
		cnt_full = (2*SIDE_W)'(groups_q) * (2*SIDE_W)'(width_q);
		b_full   = (2*SUM_W)'(sum_q) * (2*SUM_W)'(sum_q);
		plo_full = (CNT_W+LO_W)'(cnt_q) * (CNT_W+LO_W)'(sq_q[LO_W-1:0]);
		phi_full = (CNT_W+HI_W)'(cnt_q) * (CNT_W+HI_W)'(sq_q[SQ_W-1:LO_W]);
		csq_full = DVS_W'(cnt_q) * DVS_W'(cnt_q);
		diff     = {1'b0, a_q} - (NUM_W+1)'(b_q);
		// dividing by cnt << k equals shifting the dividend right by k first
		mean_dvd = DVD_W'({sum_q, FRAC_W'(0)} >> shift_q);
		mean_sat = (|div_quo[DVD_W-1:MEAN_W]) ? MEAN_MAX : div_quo[MEAN_W-1:0];
		var_sat  = (div_quo > DVD_W'(VAR_MAX)) ? VAR_MAX : div_quo[VAR_W-1:0];
		out_free = !out_valid_q || out_ready;
		pop      = (state_q == ST_IDLE) && job_valid;

		div_start = 1'b0;
		div_dvd   = mean_dvd;
		div_dvs   = DVS_W'(cnt_q);
		case (state_q)
			ST_DIFF: begin
				div_start = 1'b1;
			end
			ST_DIVM: begin
				div_start = div_done;
				div_dvd   = vnum_q;
				div_dvs   = csq_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	bmvs_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_CNT;
					end
				end
				ST_CNT:  state_q <= ST_PROD;
				ST_PROD: state_q <= ST_SUMA;
				ST_SUMA: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_DIVM;
				ST_DIVM: begin
					if (div_done) begin
						state_q <= ST_DIVV;
					end
				end
				ST_DIVV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				{groups_q, width_q, shift_q, sum_q, sq_q} <= job;
			end
			ST_CNT: begin
				cnt_q <= cnt_full[CNT_W-1:0];
			end
			ST_PROD: begin
				zero_q <= (cnt_q == '0);
				b_q    <= b_full;
				plo_q  <= plo_full;
				phi_q  <= phi_full;
				csq_q  <= csq_full;
			end
			ST_SUMA: begin
				a_q <= NUM_W'(plo_q) + (NUM_W'(phi_q) << LO_W);
			end
			ST_DIFF: begin
				// negative numerator clamps the variance to zero
				vnum_q <= diff[NUM_W] ? '0 :
					(DVD_W'({diff[NUM_W-1:0], FRAC_W'(0)}) >> {shift_q, 1'b0});
			end
			ST_DIVM: begin
				if (div_done) begin
					mean_q <= zero_q ? '0 : mean_sat;
				end
			end
			ST_OUT: begin
				// the divider holds the variance quotient until the next start
				if (out_free) begin
					mean_out_q <= mean_q;
					var_out_q  <= zero_q ? '0 : var_sat;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign mean_fx     = mean_out_q;
	assign variance_fx = var_out_q;

endmodule
